// ===== design/dbcb_pkg.sv =====
// Shared constants, types and saturation functions for the best-class box decoder.
`default_nettype none

package dbcb_pkg;

    localparam int MaxClasses = 256;
    localparam int ClassW     = 8;
    localparam int ScoreW     = 16;
    localparam int CoordW     = 16;
    localparam int GainW      = 24;
    localparam int SizeW      = 14;
    localparam int CapW       = SizeW + 4;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 24;
    localparam int NumW       = 19;
    localparam int ProdW      = NumW + GainW + 1;
    localparam int RoundShift = 17;
    localparam int ScaledW    = ProdW - RoundShift;
    localparam int LowW       = 18;
    localparam int HighW      = 19;

    localparam logic [ScoreW-1:0] ThresholdReset = 16'd16384;
    localparam logic [GainW-1:0]  GainReset      = 24'd65536;
    localparam logic [SizeW-1:0]  SizeReset      = 14'd640;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_THRESHOLD,
        CFG_PAD_X,
        CFG_PAD_Y,
        CFG_INV_GAIN,
        CFG_ORIG_W,
        CFG_ORIG_H
    } t_cfg_idx;

    typedef struct packed {
        logic              emit;
        logic [ClassW-1:0] best_class;
        logic [ScoreW-1:0] confidence;
    } t_pick;

    function automatic logic [LowW-1:0] sat_low(input logic signed [ScaledW-1:0] v);
        logic [LowW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ScaledW'(262143)) begin
            r = '1;
        end else begin
            r = v[LowW-1:0];
        end
        return r;
    endfunction

    function automatic logic [HighW-1:0] sat_high(input logic signed [ScaledW-1:0] v,
                                                  input logic [CapW-1:0] cap);
        logic signed [ScaledW-1:0] t;
        logic signed [ScaledW-1:0] cap_s;
        cap_s = $signed(ScaledW'(cap));
        t = v;
        if (t > cap_s) begin
            t = cap_s;
        end
        if (t > $signed(ScaledW'(131071))) begin
            t = $signed(ScaledW'(131071));
        end
        if (t < -$signed(ScaledW'(262144))) begin
            t = -$signed(ScaledW'(262144));
        end
        return t[HighW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/dbcb_argmax.sv =====
// Running best-class tracker over the class scores of one anchor.
`default_nettype none

module dbcb_argmax #(
    parameter int MAX_CLASSES = dbcb_pkg::MaxClasses
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_fire,
    input  wire [dbcb_pkg::ScoreW-1:0]   i_score,
    input  wire                          i_last,
    input  wire [dbcb_pkg::ScoreW-1:0]   i_threshold,
    output dbcb_pkg::t_pick              o_pick
);

    logic [dbcb_pkg::ScoreW-1:0] r_best_score, n_best_score;
    logic [dbcb_pkg::ClassW-1:0] r_best_class, n_best_class;
    logic [dbcb_pkg::ClassW-1:0] r_count, n_count;
    logic                        r_found, n_found;
    logic [dbcb_pkg::ScoreW-1:0] bar;
    logic                        pass;

    assign bar  = r_found ? r_best_score : i_threshold;
    assign pass = i_score > bar;

    always_comb begin
        n_best_score = pass ? i_score : r_best_score;
        n_best_class = pass ? r_count : r_best_class;
        n_found      = r_found | pass;
        if (r_count == dbcb_pkg::ClassW'(MAX_CLASSES - 1)) begin
            n_count = '0;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    assign o_pick.emit       = i_last & n_found;
    assign o_pick.best_class = n_best_class;
    assign o_pick.confidence = n_best_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_class <= '0;
            r_count      <= '0;
            r_found      <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_best_score <= '0;
                r_best_class <= '0;
                r_count      <= '0;
                r_found      <= 1'b0;
            end else begin
                r_best_score <= n_best_score;
                r_best_class <= n_best_class;
                r_count      <= n_count;
                r_found      <= n_found;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/dbcb_scale.sv =====
// One box corner: padding removed, scaled by the inverse gain and rounded to nearest.
`default_nettype none

module dbcb_scale (
    input  wire [dbcb_pkg::CoordW-1:0]          i_center,
    input  wire [dbcb_pkg::CoordW-1:0]          i_size,
    input  wire [dbcb_pkg::CoordW-1:0]          i_pad,
    input  wire [dbcb_pkg::GainW-1:0]           i_gain,
    input  wire                                 i_far,
    output logic signed [dbcb_pkg::ScaledW-1:0] o_scaled
);

    logic signed [dbcb_pkg::NumW-1:0]    center2;
    logic signed [dbcb_pkg::NumW-1:0]    size_ext;
    logic signed [dbcb_pkg::NumW-1:0]    pad2;
    logic signed [dbcb_pkg::NumW-1:0]    num;
    logic signed [dbcb_pkg::GainW:0]     gain_s;
    logic signed [dbcb_pkg::ProdW-1:0]   prod;
    logic signed [dbcb_pkg::ProdW-1:0]   rounded;

    assign center2  = $signed({2'b00, i_center, 1'b0});
    assign size_ext = $signed({3'b000, i_size});
    assign pad2     = $signed({2'b00, i_pad, 1'b0});
    assign num      = i_far ? (center2 + size_ext - pad2) : (center2 - size_ext - pad2);
    assign gain_s   = $signed({1'b0, i_gain});
    assign prod     = num * gain_s;
    assign rounded  = prod + $signed(dbcb_pkg::ProdW'(65536));
    assign o_scaled = $signed(rounded[dbcb_pkg::ProdW-1:dbcb_pkg::RoundShift]);

endmodule

`default_nettype wire

// ===== design/detection_best_class_box_decode.sv =====
// Top level of the best-class selector with letterbox box decode.
// A result is loaded into the result register from the input register that holds the last score.
// Throughput: one class score per cycle unless a full result register is stalled, set by the
// single-pass argmax and corner logic between the input register and the result register.
// Reset (synchronous, active low) empties both registers, clears the running best class
// and restores the configuration registers to their defaults.
`default_nettype none

module detection_best_class_box_decode #(
    parameter int MAX_CLASSES = dbcb_pkg::MaxClasses
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [dbcb_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  wire [dbcb_pkg::CfgDataW-1:0]        i_cfg_data,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire [dbcb_pkg::CoordW-1:0]          i_center_x,
    input  wire [dbcb_pkg::CoordW-1:0]          i_center_y,
    input  wire [dbcb_pkg::CoordW-1:0]          i_box_width,
    input  wire [dbcb_pkg::CoordW-1:0]          i_box_height,
    input  wire [dbcb_pkg::ScoreW-1:0]          i_class_score,
    input  wire                                 i_last_score,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [dbcb_pkg::LowW-1:0]           o_left_x,
    output logic [dbcb_pkg::LowW-1:0]           o_top_y,
    output logic signed [dbcb_pkg::HighW-1:0]   o_right_x,
    output logic signed [dbcb_pkg::HighW-1:0]   o_bottom_y,
    output logic [dbcb_pkg::ClassW-1:0]         o_best_class,
    output logic [dbcb_pkg::ScoreW-1:0]         o_confidence
);

    logic [dbcb_pkg::ScoreW-1:0] r_threshold;
    logic [dbcb_pkg::CoordW-1:0] r_pad_x;
    logic [dbcb_pkg::CoordW-1:0] r_pad_y;
    logic [dbcb_pkg::GainW-1:0]  r_gain;
    logic [dbcb_pkg::SizeW-1:0]  r_orig_w;
    logic [dbcb_pkg::SizeW-1:0]  r_orig_h;

    logic                        r_s1_valid;
    logic [dbcb_pkg::CoordW-1:0] r_s1_cx;
    logic [dbcb_pkg::CoordW-1:0] r_s1_cy;
    logic [dbcb_pkg::CoordW-1:0] r_s1_w;
    logic [dbcb_pkg::CoordW-1:0] r_s1_h;
    logic [dbcb_pkg::ScoreW-1:0] r_s1_score;
    logic                        r_s1_last;

    logic                               r_out_valid;
    logic [dbcb_pkg::LowW-1:0]          r_left_x;
    logic [dbcb_pkg::LowW-1:0]          r_top_y;
    logic [dbcb_pkg::HighW-1:0]         r_right_x;
    logic [dbcb_pkg::HighW-1:0]         r_bottom_y;
    logic [dbcb_pkg::ClassW-1:0]        r_best_class;
    logic [dbcb_pkg::ScoreW-1:0]        r_confidence;

    dbcb_pkg::t_pick                    pick;
    logic                               out_ready;
    logic                               s1_fire;
    logic                               load_out;
    logic signed [dbcb_pkg::ScaledW-1:0] x0, y0, x1, y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= dbcb_pkg::ThresholdReset;
            r_pad_x     <= '0;
            r_pad_y     <= '0;
            r_gain      <= dbcb_pkg::GainReset;
            r_orig_w    <= dbcb_pkg::SizeReset;
            r_orig_h    <= dbcb_pkg::SizeReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dbcb_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[dbcb_pkg::ScoreW-1:0];
                dbcb_pkg::CFG_PAD_X:     r_pad_x     <= i_cfg_data[dbcb_pkg::CoordW-1:0];
                dbcb_pkg::CFG_PAD_Y:     r_pad_y     <= i_cfg_data[dbcb_pkg::CoordW-1:0];
                dbcb_pkg::CFG_INV_GAIN:  r_gain      <= i_cfg_data[dbcb_pkg::GainW-1:0];
                dbcb_pkg::CFG_ORIG_W:    r_orig_w    <= i_cfg_data[dbcb_pkg::SizeW-1:0];
                dbcb_pkg::CFG_ORIG_H:    r_orig_h    <= i_cfg_data[dbcb_pkg::SizeW-1:0];
                default: begin
                end
            endcase
        end
    end

    dbcb_argmax #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_argmax (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_score     (r_s1_score),
        .i_last      (r_s1_last),
        .i_threshold (r_threshold),
        .o_pick      (pick)
    );

    dbcb_scale u_x0 (
        .i_center (r_s1_cx), .i_size (r_s1_w), .i_pad (r_pad_x),
        .i_gain (r_gain), .i_far (1'b0), .o_scaled (x0)
    );
    dbcb_scale u_y0 (
        .i_center (r_s1_cy), .i_size (r_s1_h), .i_pad (r_pad_y),
        .i_gain (r_gain), .i_far (1'b0), .o_scaled (y0)
    );
    dbcb_scale u_x1 (
        .i_center (r_s1_cx), .i_size (r_s1_w), .i_pad (r_pad_x),
        .i_gain (r_gain), .i_far (1'b1), .o_scaled (x1)
    );
    dbcb_scale u_y1 (
        .i_center (r_s1_cy), .i_size (r_s1_h), .i_pad (r_pad_y),
        .i_gain (r_gain), .i_far (1'b1), .o_scaled (y1)
    );

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_fire   = r_s1_valid && (!pick.emit || out_ready);
    assign load_out  = s1_fire && pick.emit;
    assign o_stall   = r_s1_valid && !s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_s1_cx    <= i_center_x;
            r_s1_cy    <= i_center_y;
            r_s1_w     <= i_box_width;
            r_s1_h     <= i_box_height;
            r_s1_score <= i_class_score;
            r_s1_last  <= i_last_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_left_x     <= dbcb_pkg::sat_low(x0);
            r_top_y      <= dbcb_pkg::sat_low(y0);
            r_right_x    <= dbcb_pkg::sat_high(x1, {r_orig_w, 4'b0000});
            r_bottom_y   <= dbcb_pkg::sat_high(y1, {r_orig_h, 4'b0000});
            r_best_class <= pick.best_class;
            r_confidence <= pick.confidence;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_x     = r_left_x;
    assign o_top_y      = r_top_y;
    assign o_right_x    = $signed(r_right_x);
    assign o_bottom_y   = $signed(r_bottom_y);
    assign o_best_class = r_best_class;
    assign o_confidence = r_confidence;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_last))
        else $error("A result appeared without a last-score transaction.");

    a_emit_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid)
        else $error("An emitted result did not reach the output register.");

    a_empty_stage_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("The input was stalled while the input register was empty.");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the best-class selector with letterbox box decode.
`timescale 1ns / 1ps

module testbench;

    localparam int     DrainCycles = 4;
    localparam int     LongHold    = 200;
    localparam longint RoundHalf   = 65536;

    localparam logic [dbcb_pkg::CfgIdxW-1:0] CfgSpareLo = 3'd6;
    localparam logic [dbcb_pkg::CfgIdxW-1:0] CfgSpareHi = 3'd7;

    typedef enum int {
        SET_DEFAULT,
        SET_WIDE_OPEN,
        SET_CLOSED,
        SET_TYPICAL,
        SET_ZERO_GAIN,
        SET_ODD_SIZES
    } t_setting;

    typedef struct {
        logic [dbcb_pkg::CoordW-1:0] cx;
        logic [dbcb_pkg::CoordW-1:0] cy;
        logic [dbcb_pkg::CoordW-1:0] w;
        logic [dbcb_pkg::CoordW-1:0] h;
        logic [dbcb_pkg::ScoreW-1:0] score;
        logic                        last;
    } t_score_item;

    typedef struct {
        logic [dbcb_pkg::LowW-1:0]   left;
        logic [dbcb_pkg::LowW-1:0]   top;
        logic [dbcb_pkg::HighW-1:0]  right;
        logic [dbcb_pkg::HighW-1:0]  bottom;
        logic [dbcb_pkg::ClassW-1:0] cls;
        logic [dbcb_pkg::ScoreW-1:0] conf;
    } t_box_result;

    class box_decode_board;
        logic [dbcb_pkg::ScoreW-1:0] thr;
        logic [dbcb_pkg::CoordW-1:0] pad_x;
        logic [dbcb_pkg::CoordW-1:0] pad_y;
        logic [dbcb_pkg::GainW-1:0]  gain;
        logic [dbcb_pkg::SizeW-1:0]  orig_w;
        logic [dbcb_pkg::SizeW-1:0]  orig_h;
        logic [dbcb_pkg::ScoreW-1:0] best_score;
        logic [dbcb_pkg::ClassW-1:0] best_class;
        logic [dbcb_pkg::ClassW-1:0] class_idx;
        logic                        found;
        t_box_result                 pending_boxes[$];
        int                          mismatches;

        function new();
            thr = dbcb_pkg::ThresholdReset;
            pad_x = '0;
            pad_y = '0;
            gain = dbcb_pkg::GainReset;
            orig_w = dbcb_pkg::SizeReset;
            orig_h = dbcb_pkg::SizeReset;
            mismatches = 0;
            clear_anchor();
        endfunction

        function void clear_anchor();
            best_score = '0;
            best_class = '0;
            class_idx = '0;
            found = 1'b0;
        endfunction

        function void write_reg(logic [dbcb_pkg::CfgIdxW-1:0] idx,
                                logic [dbcb_pkg::CfgDataW-1:0] data);
            case (idx)
                dbcb_pkg::CFG_THRESHOLD: thr = data[dbcb_pkg::ScoreW-1:0];
                dbcb_pkg::CFG_PAD_X:     pad_x = data[dbcb_pkg::CoordW-1:0];
                dbcb_pkg::CFG_PAD_Y:     pad_y = data[dbcb_pkg::CoordW-1:0];
                dbcb_pkg::CFG_INV_GAIN:  gain = data[dbcb_pkg::GainW-1:0];
                dbcb_pkg::CFG_ORIG_W:    orig_w = data[dbcb_pkg::SizeW-1:0];
                dbcb_pkg::CFG_ORIG_H:    orig_h = data[dbcb_pkg::SizeW-1:0];
                default: ;
            endcase
        endfunction

        function longint scaled(longint num);
            return (num * longint'(gain) + RoundHalf) >>> dbcb_pkg::RoundShift;
        endfunction

        function logic [dbcb_pkg::LowW-1:0] floor_sat(longint v);
            if (v < 0) return '0;
            if (v > 262143) return '1;
            return v[dbcb_pkg::LowW-1:0];
        endfunction

        function logic [dbcb_pkg::HighW-1:0] cap_sat(longint v, longint cap);
            if (v > cap) v = cap;
            if (v > 131071) v = 131071;
            if (v < -262144) v = -262144;
            return v[dbcb_pkg::HighW-1:0];
        endfunction

        function void note_score(t_score_item it);
            logic [dbcb_pkg::ScoreW-1:0] bar;
            t_box_result                 r;
            longint                      cx2, cy2, bw, bh, px2, py2;
            bar = found ? best_score : thr;
            if (it.score > bar) begin
                best_score = it.score;
                best_class = class_idx;
                found = 1'b1;
            end
            class_idx = (int'(class_idx) == dbcb_pkg::MaxClasses - 1) ? '0 : class_idx + 1'b1;
            if (!it.last) return;
            if (found) begin
                cx2 = 2 * longint'(it.cx);
                cy2 = 2 * longint'(it.cy);
                bw = longint'(it.w);
                bh = longint'(it.h);
                px2 = 2 * longint'(pad_x);
                py2 = 2 * longint'(pad_y);
                r.left = floor_sat(scaled(cx2 - bw - px2));
                r.top = floor_sat(scaled(cy2 - bh - py2));
                r.right = cap_sat(scaled(cx2 + bw - px2), 16 * longint'(orig_w));
                r.bottom = cap_sat(scaled(cy2 + bh - py2), 16 * longint'(orig_h));
                r.cls = best_class;
                r.conf = best_score;
                pending_boxes.push_back(r);
            end
            clear_anchor();
        endfunction

        function int pending();
            return pending_boxes.size();
        endfunction

        function void check_field(string name, logic [dbcb_pkg::HighW-1:0] want,
                                  logic [dbcb_pkg::HighW-1:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
            end
        endfunction

        function void check_box(t_box_result got);
            t_box_result want;
            if (pending_boxes.size() == 0) begin
                mismatches++;
                $display("%0t: box result with none expected, expected none, got class %0d",
                         $time, got.cls);
                return;
            end
            want = pending_boxes.pop_front();
            check_field("left_x", want.left, got.left);
            check_field("top_y", want.top, got.top);
            check_field("right_x", want.right, got.right);
            check_field("bottom_y", want.bottom, got.bottom);
            check_field("best_class", want.cls, got.cls);
            check_field("confidence", want.conf, got.conf);
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [dbcb_pkg::CfgIdxW-1:0]        i_cfg_idx = '0;
    logic [dbcb_pkg::CfgDataW-1:0]       i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [dbcb_pkg::CoordW-1:0]         i_center_x = '0;
    logic [dbcb_pkg::CoordW-1:0]         i_center_y = '0;
    logic [dbcb_pkg::CoordW-1:0]         i_box_width = '0;
    logic [dbcb_pkg::CoordW-1:0]         i_box_height = '0;
    logic [dbcb_pkg::ScoreW-1:0]         i_class_score = '0;
    logic                                i_last_score = 1'b0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [dbcb_pkg::LowW-1:0]           o_left_x;
    logic [dbcb_pkg::LowW-1:0]           o_top_y;
    logic signed [dbcb_pkg::HighW-1:0]   o_right_x;
    logic signed [dbcb_pkg::HighW-1:0]   o_bottom_y;
    logic [dbcb_pkg::ClassW-1:0]         o_best_class;
    logic [dbcb_pkg::ScoreW-1:0]         o_confidence;

    box_decode_board board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;

    detection_best_class_box_decode dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_center_x(i_center_x),
        .i_center_y(i_center_y),
        .i_box_width(i_box_width),
        .i_box_height(i_box_height),
        .i_class_score(i_class_score),
        .i_last_score(i_last_score),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_left_x(o_left_x),
        .o_top_y(o_top_y),
        .o_right_x(o_right_x),
        .o_bottom_y(o_bottom_y),
        .o_best_class(o_best_class),
        .o_confidence(o_confidence)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

    // The receiver counts out a long hold-off on its own when one is requested.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            i_stall <= 1'b1;
            hold_left <= LongHold;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_box(t_box_result'{o_left_x, o_top_y, o_right_x, o_bottom_y,
                                          o_best_class, o_confidence});
        end
    end

    function automatic t_score_item make_item(logic [dbcb_pkg::CoordW-1:0] cx,
                                              logic [dbcb_pkg::CoordW-1:0] cy,
                                              logic [dbcb_pkg::CoordW-1:0] w,
                                              logic [dbcb_pkg::CoordW-1:0] h,
                                              logic [dbcb_pkg::ScoreW-1:0] score,
                                              logic last);
        t_score_item it;
        it.cx = cx;
        it.cy = cy;
        it.w = w;
        it.h = h;
        it.score = score;
        it.last = last;
        return it;
    endfunction

    function automatic t_score_item rand_item(logic [dbcb_pkg::ScoreW-1:0] score, logic last);
        t_score_item it;
        int          shape;
        shape = $urandom_range(9);
        it = make_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       score, last);
        if (shape == 0) begin
            it = make_item('0, '0, '0, '0, score, last);
        end else if (shape == 1) begin
            it = make_item('1, '1, '1, '1, score, last);
        end else if (shape < 7) begin
            it = make_item(16'($urandom_range(12000)), 16'($urandom_range(12000)),
                           16'($urandom_range(6000)), 16'($urandom_range(6000)),
                           score, last);
        end
        return it;
    endfunction

    function automatic logic [dbcb_pkg::ScoreW-1:0] pick_score(int mode);
        int v;
        case (mode)
            0: v = $urandom_range(65535);
            1: v = int'($urandom_range(4)) - 2 + int'(board.thr);
            2: v = int'($urandom_range(2)) + 1 + int'(board.thr);
            default: v = $urandom_range(1) ? 65535 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[dbcb_pkg::ScoreW-1:0];
    endfunction

    task automatic push_score(t_score_item it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_center_x <= it.cx;
        i_center_y <= it.cy;
        i_box_width <= it.w;
        i_box_height <= it.h;
        i_class_score <= it.score;
        i_last_score <= it.last;
        do @(posedge i_clk); while (o_stall);
        board.note_score(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dbcb_pkg::CfgIdxW-1:0] idx,
                             logic [dbcb_pkg::CfgDataW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic load_settings(t_setting kind);
        logic [dbcb_pkg::CfgDataW-1:0] thr, px, py, g, w, h;
        case (kind)
            SET_DEFAULT: begin
                thr = 16384; px = 0; py = 0; g = 65536; w = 640; h = 640;
            end
            SET_WIDE_OPEN: begin
                thr = 0; px = 65535; py = 65535; g = 24'hFFFFFF; w = 8192; h = 8192;
            end
            SET_CLOSED: begin
                thr = 65535;
                px = 24'($urandom_range(4096)); py = 24'($urandom_range(4096));
                g = 24'($urandom_range(131072));
                w = 24'($urandom_range(16383)); h = 24'($urandom_range(16383));
            end
            SET_TYPICAL: begin
                thr = 24'($urandom_range(8000, 50000));
                px = 24'($urandom_range(2048)); py = 24'($urandom_range(2048));
                g = 24'($urandom_range(16384, 262144));
                w = 24'($urandom_range(1, 8192)); h = 24'($urandom_range(1, 8192));
            end
            SET_ZERO_GAIN: begin
                thr = 24'($urandom_range(30000)); px = 24'($urandom_range(65535));
                py = 24'($urandom_range(65535)); g = 0; w = 0;
                h = 24'($urandom_range(8193, 16383));
            end
            default: begin
                thr = 24'($urandom_range(40000));
                px = 24'($urandom_range(1024)); py = 24'($urandom_range(1024));
                g = 24'($urandom_range(24'hFFFFFF)); w = 1;
                h = 24'($urandom_range(16383));
            end
        endcase
        write_reg(dbcb_pkg::CFG_THRESHOLD, {8'($urandom), thr[dbcb_pkg::ScoreW-1:0]});
        write_reg(dbcb_pkg::CFG_PAD_X, {8'($urandom), px[dbcb_pkg::CoordW-1:0]});
        write_reg(dbcb_pkg::CFG_PAD_Y, {8'($urandom), py[dbcb_pkg::CoordW-1:0]});
        write_reg(dbcb_pkg::CFG_INV_GAIN, g);
        write_reg(dbcb_pkg::CFG_ORIG_W, {10'($urandom), w[dbcb_pkg::SizeW-1:0]});
        write_reg(dbcb_pkg::CFG_ORIG_H, {10'($urandom), h[dbcb_pkg::SizeW-1:0]});
        write_reg(CfgSpareLo, 24'($urandom));
        write_reg(CfgSpareHi, 24'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_anchors(int item_budget);
        int sent, n, mode;
        sent = 0;
        while (sent < item_budget) begin
            n = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            mode = $urandom_range(3);
            for (int k = 0; k < n; k++) begin
                push_score(rand_item(pick_score(mode), k == n - 1));
            end
            sent += n;
        end
    endtask

    initial begin : stimulus
        int       idle_send[3] = '{26, 86, 0};
        int       idle_recv[3] = '{86, 26, 0};
        t_setting order[6] = '{SET_TYPICAL, SET_WIDE_OPEN, SET_ZERO_GAIN,
                               SET_ODD_SIZES, SET_CLOSED, SET_DEFAULT};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_score(make_item('1, '1, '1, '1, '1, 1'b1));
        push_score(make_item(16'h1234, 16'h0ABC, 16'h0100, 16'h0200, 16384, 1'b1));
        push_score(make_item('0, '0, '0, '0, 16385, 1'b1));
        push_score(make_item('1, '0, '1, '0, 30000, 1'b0));
        push_score(make_item('0, '1, '0, '1, 30000, 1'b0));
        push_score(make_item(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 20000, 1'b0));
        push_score(make_item(5000, 5000, 800, 600, 30000, 1'b1));
        push_score(make_item(16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 0, 1'b0));
        push_score(make_item(7000, 7000, 100, 100, 65535, 1'b0));
        push_score(make_item(100, 100, 4000, 4000, 65535, 1'b1));
        push_score(make_item(9000, 9000, 20, 20, 17000, 1'b0));
        push_score(make_item(10000, 10000, 6000, 6000, 18000, 1'b1));
        drain();

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = idle_send[p];
            recv_idle_pct = idle_recv[p];
            if (p == 2) begin
                load_settings(SET_DEFAULT);
                hold_request = 1'b1;
                for (int k = 0; k < 40; k++) begin
                    push_score(rand_item('1, 1'b1));
                end
                drain();
                // More classes than the counter holds, with the winner after the wrap.
                for (int k = 0; k < 300; k++) begin
                    push_score(rand_item(k == 270 ? 16'hFFFF : 16'($urandom_range(60000)),
                                         k == 299));
                end
                drain();
            end
            foreach (order[s]) begin
                load_settings(order[s]);
                run_anchors(order[s] == SET_CLOSED ? 40 : 85);
                drain();
            end
        end

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dbcb_pkg.sv
design/dbcb_argmax.sv
design/dbcb_scale.sv
design/detection_best_class_box_decode.sv
verif/testbench.sv
